FILE: rtl/tvfs_pkg.sv
// ----------------------------------------------------------------------------
// tvfs_pkg
// Shared types and constants of the timestamped value floor store.
// ----------------------------------------------------------------------------
package tvfs_pkg;

	localparam int KEYS_DEF  = 16;
	localparam int DEPTH_DEF = 64;

	localparam int SLOT_W  = 4;
	localparam int STAMP_W = 31;
	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_COUNT,
		S_FIRST,
		S_PROBE
	} state_t;

	// outcome of one binary search probe
	typedef struct packed {
		logic hit;   // stamp equals request
		logic less;  // stamp below request
		logic last;  // interval is exhausted after this probe
	} probe_t;

endpackage

FILE: rtl/tvfs_probe.sv
// ----------------------------------------------------------------------------
// tvfs_probe
// Compare and interval update of one binary search step.
// ----------------------------------------------------------------------------
module tvfs_probe
	import tvfs_pkg::*;
#(
	parameter int IW = 6
) (
	input  logic [IW-1:0]      lo,
	input  logic [IW-1:0]      hi,
	input  logic [IW-1:0]      mid,
	input  logic [STAMP_W-1:0] probe_stamp,
	input  logic [STAMP_W-1:0] req_stamp,
	output probe_t             flags,
	output logic [IW-1:0]      next_lo,
	output logic [IW-1:0]      next_hi,
	output logic [IW-1:0]      next_mid
);

	logic [IW:0] mid_sum;

	always_comb begin
		flags.hit  = (probe_stamp == req_stamp);
		flags.less = (probe_stamp < req_stamp);
		// lo <= mid <= hi, so the interval closes when mid sits on the bound that does not move
		flags.last = flags.less ? (mid == hi) : (mid == lo);
		next_lo    = flags.less ? IW'(mid + IW'(1)) : lo;
		next_hi    = flags.less ? hi : IW'(mid - IW'(1));
		mid_sum    = {1'b0, next_lo} + {1'b0, next_hi};
		next_mid   = IW'(mid_sum >> 1);
	end

endmodule

FILE: rtl/timestamped_value_floor_store.sv
// A set, or a get on an empty list, ends in S_COUNT; a get below the first stamp
// ends in S_FIRST; any other get runs binary search probes in S_PROBE until a hit
// or until the interval is exhausted.
// One request at a time: busy stays high until the result strobe; the next
// request may be accepted in the strobe cycle. The receiver cannot stall.
// After reset a clearing pass zeroes the per-key counts, with busy high.
// ----------------------------------------------------------------------------
// timestamped_value_floor_store
// Per-key append-only lists of (stamp, value) pairs with a floor lookup by
// binary search, run one probe a cycle on a shared compare unit.
// ----------------------------------------------------------------------------
module timestamped_value_floor_store
	import tvfs_pkg::*;
#(
	parameter int KEYS  = KEYS_DEF,
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [SLOT_W-1:0]  key_slot,
	input  logic [STAMP_W-1:0] stamp,
	input  logic [VALUE_W-1:0] value_word,
	output logic               done,
	output logic [1:0]         status,
	output logic [VALUE_W-1:0] found_value
);

	localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int ENTRIES = KEYS * DEPTH;
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int EW = STAMP_W + VALUE_W;

	// storage
	logic [CW-1:0] cnt_mem [KEYS];
	logic [EW-1:0] ent_mem [ENTRIES];
	logic [CW-1:0] cnt_rd_q;
	logic [EW-1:0] ent_rd_q;

	state_t state_q, state_d;

	// request registers
	logic               act_q;
	logic               slot_ok_q;
	logic [KW-1:0]      slot_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [VALUE_W-1:0] value_q;
	logic [AW-1:0]      base_q;

	// search registers
	logic [IW-1:0]      lo_q, hi_q, mid_q;
	logic               best_vld_q;
	logic [VALUE_W-1:0] best_val_q;
	logic [KW-1:0]      clr_q;

	logic               done_q;
	status_t            status_q;
	logic [VALUE_W-1:0] found_q;

	// control
	logic               accept;
	logic [KW-1:0]      in_slot;
	logic               cnt_we;
	logic [KW-1:0]      cnt_waddr;
	logic [CW-1:0]      cnt_wdata;
	logic               ent_we;
	logic [AW-1:0]      ent_waddr;
	logic [AW-1:0]      ent_raddr;
	logic               load_search;
	logic               step;
	logic               take_best;
	logic               fin;
	status_t            fin_status;
	logic [VALUE_W-1:0] fin_value;

	logic [STAMP_W-1:0] rd_stamp;
	logic [VALUE_W-1:0] rd_value;
	probe_t             pr;
	logic [IW-1:0]      pr_lo, pr_hi, pr_mid;

	assign rd_stamp = ent_rd_q[EW-1:VALUE_W];
	assign rd_value = ent_rd_q[VALUE_W-1:0];
	assign in_slot  = KW'(key_slot);
	assign accept   = start && !busy;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_q;

	tvfs_probe #(
		.IW(IW)
	) u_probe (
		.lo          (lo_q),
		.hi          (hi_q),
		.mid         (mid_q),
		.probe_stamp (rd_stamp),
		.req_stamp   (stamp_q),
		.flags       (pr),
		.next_lo     (pr_lo),
		.next_hi     (pr_hi),
		.next_mid    (pr_mid)
	);

	always_comb begin
		state_d     = state_q;
		cnt_we      = 1'b0;
		cnt_waddr   = slot_q;
		cnt_wdata   = CW'(cnt_rd_q + CW'(1));
		ent_we      = 1'b0;
		ent_waddr   = AW'(base_q + AW'(cnt_rd_q));
		ent_raddr   = base_q;
		load_search = 1'b0;
		step        = 1'b0;
		take_best   = 1'b0;
		fin         = 1'b0;
		fin_status  = ST_OK;
		fin_value   = '0;
		case (state_q)
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
				if (32'(clr_q) == KEYS - 1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_COUNT;
				end
			end
			S_COUNT: begin
				if (!act_q) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (!slot_ok_q || cnt_rd_q >= CW'(DEPTH)) begin
						fin_status = ST_FULL;
					end else begin
						cnt_we = 1'b1;
						ent_we = 1'b1;
					end
				end else if (!slot_ok_q || cnt_rd_q == '0) begin
					fin        = 1'b1;
					fin_status = ST_MISS;
					state_d    = S_IDLE;
				end else begin
					// fetch the first entry for the below-first check
					load_search = 1'b1;
					state_d     = S_FIRST;
				end
			end
			S_FIRST: begin
				// first stamp above the request: neither equal nor below
				if (!pr.hit && !pr.less) begin
					fin        = 1'b1;
					fin_status = ST_MISS;
					state_d    = S_IDLE;
				end else begin
					ent_raddr = AW'(base_q + AW'(mid_q));
					state_d   = S_PROBE;
				end
			end
			S_PROBE: begin
				if (pr.hit) begin
					fin       = 1'b1;
					fin_value = rd_value;
					state_d   = S_IDLE;
				end else if (pr.last) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (pr.less) begin
						fin_value = rd_value;
					end else if (best_vld_q) begin
						fin_value = best_val_q;
					end else begin
						fin_status = ST_MISS;
					end
				end else begin
					step      = 1'b1;
					take_best = pr.less;
					ent_raddr = AW'(base_q + AW'(pr_mid));
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= KW'(clr_q + KW'(1));
			end
			done_q <= fin;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= action;
			slot_q    <= in_slot;
			slot_ok_q <= (32'(key_slot) < KEYS);
			stamp_q   <= stamp;
			value_q   <= value_word;
			base_q    <= AW'(AW'(in_slot) * AW'(DEPTH));
		end
		if (load_search) begin
			lo_q       <= '0;
			hi_q       <= IW'(cnt_rd_q - CW'(1));
			mid_q      <= IW'((cnt_rd_q - CW'(1)) >> 1);
			best_vld_q <= 1'b0;
		end
		if (step) begin
			lo_q  <= pr_lo;
			hi_q  <= pr_hi;
			mid_q <= pr_mid;
		end
		if (take_best) begin
			best_vld_q <= 1'b1;
			best_val_q <= rd_value;
		end
		if (fin) begin
			status_q <= fin_status;
			found_q  <= fin_value;
		end
	end

	// count memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[in_slot];
	end

	// entry memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= {stamp_q, value_q};
		end
		ent_rd_q <= ent_mem[ent_raddr];
	end

endmodule

FILE: verif/tb_timestamped_value_floor_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamped_value_floor_store
// Self-checking bench for the per-key floor lookup store. Requests go in over
// start/busy. A scoreboard model of the per-key lists predicts status and
// value for every accepted request, and each done strobe is checked against
// the oldest prediction. Directed corners run first, then a full list, then
// random traffic under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_timestamped_value_floor_store;
	import tvfs_pkg::*;

	localparam int KEYS        = KEYS_DEF;
	localparam int DEPTH       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

	localparam logic ACT_SET = 1'b0;
	localparam logic ACT_GET = 1'b1;

	typedef struct {
		status_t            status;
		logic [VALUE_W-1:0] value;
	} floor_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               action;
	logic [SLOT_W-1:0]  key_slot;
	logic [STAMP_W-1:0] stamp;
	logic [VALUE_W-1:0] value_word;
	logic               done;
	logic [1:0]         status;
	logic [VALUE_W-1:0] found_value;

	// scoreboard copy of the store
	logic [6:0]         list_count [KEYS];
	logic [STAMP_W-1:0] list_stamps [KEYS][DEPTH];
	logic [VALUE_W-1:0] list_values [KEYS][DEPTH];

	floor_result_t pending_results[$];
	int error_count;
	int cycle_count;
	int idle_pct;

	timestamped_value_floor_store #(
		.KEYS (KEYS),
		.DEPTH(DEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.key_slot   (key_slot),
		.stamp      (stamp),
		.value_word (value_word),
		.done       (done),
		.status     (status),
		.found_value(found_value)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// floor search with the same probe order as the block, early out on exact match
	function automatic floor_result_t predict_floor(input logic act, input logic [SLOT_W-1:0] slot,
			input logic [STAMP_W-1:0] stp, input logic [VALUE_W-1:0] val);
		floor_result_t r;
		int n, lo, hi, mid, best;
		r.status = ST_OK;
		r.value  = '0;
		if (act == ACT_SET) begin
			if (int'(slot) >= KEYS || int'(list_count[slot]) >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				list_stamps[slot][list_count[slot]] = stp;
				list_values[slot][list_count[slot]] = val;
				list_count[slot] = list_count[slot] + 7'd1;
			end
			return r;
		end
		if (int'(slot) >= KEYS) begin
			r.status = ST_MISS;
			return r;
		end
		n = int'(list_count[slot]);
		if (n == 0 || stp < list_stamps[slot][0]) begin
			r.status = ST_MISS;
			return r;
		end
		lo = 0;
		hi = n - 1;
		best = -1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (list_stamps[slot][mid] == stp) begin
				r.value = list_values[slot][mid];
				return r;
			end else if (list_stamps[slot][mid] < stp) begin
				best = mid;
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		if (best < 0)
			r.status = ST_MISS;
		else
			r.value = list_values[slot][best];
		return r;
	endfunction

	// called at a falling edge; returns at a falling edge with start still high
	// unless an idle gap was inserted
	task automatic send_request(input logic act, input logic [SLOT_W-1:0] slot,
			input logic [STAMP_W-1:0] stp, input logic [VALUE_W-1:0] val);
		int gap;
		floor_result_t pred;
		start      <= 1'b1;
		action     <= act;
		key_slot   <= slot;
		stamp      <= stp;
		value_word <= val;
		do @(posedge clk); while (busy !== 1'b0);
		pred = predict_floor(act, slot, stp, val);
		pending_results = {pending_results, pred};
		@(negedge clk);
		gap = 0;
		while (gap < 30 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		floor_result_t exp_r;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request pending: status %0d value %h",
					$time, status, found_value);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status mismatch: expected %0d actual %0d",
						$time, exp_r.status, status);
					error_count++;
				end
				if (found_value !== exp_r.value) begin
					$display("%0t: found_value mismatch: expected %h actual %h",
						$time, exp_r.value, found_value);
					error_count++;
				end
			end
		end
	end

	task automatic test_directed();
		idle_pct = 0;
		send_request(ACT_GET, 4'd0, 31'd5, 32'h0);            // empty list
		send_request(ACT_GET, 4'd15, STAMP_MAX, 32'hFFFFFFFF);
		send_request(ACT_SET, 4'd0, 31'd100, 32'h0);
		send_request(ACT_SET, 4'd0, 31'd200, 32'hFFFFFFFF);
		send_request(ACT_SET, 4'd0, 31'd300, 32'hA5A5A5A5);
		send_request(ACT_GET, 4'd0, 31'd200, 32'h12345678);   // exact
		send_request(ACT_GET, 4'd0, 31'd250, 32'h0);          // floor
		send_request(ACT_GET, 4'd0, 31'd99, 32'h0);           // below first
		send_request(ACT_GET, 4'd0, STAMP_MAX, 32'h0);
		send_request(ACT_GET, 4'd0, 31'd0, 32'h0);
		send_request(ACT_SET, 4'd15, 31'd0, 32'h00000001);
		send_request(ACT_GET, 4'd15, 31'd0, 32'h0);
		send_request(ACT_SET, 4'd15, STAMP_MAX, 32'h5A5A5A5A);
		send_request(ACT_GET, 4'd15, STAMP_MAX, 32'h0);
		send_request(ACT_GET, 4'd15, STAMP_MAX - 31'd1, 32'h0);
		// out of order stamps: search follows its own probes
		send_request(ACT_SET, 4'd7, 31'd50, 32'h00000050);
		send_request(ACT_SET, 4'd7, 31'd10, 32'h00000010);
		send_request(ACT_SET, 4'd7, 31'd90, 32'h00000090);
		send_request(ACT_SET, 4'd7, 31'd30, 32'h00000030);
		send_request(ACT_GET, 4'd7, 31'd30, 32'h0);
		send_request(ACT_GET, 4'd7, 31'd40, 32'h0);
		send_request(ACT_GET, 4'd7, 31'd5, 32'h0);
		send_request(ACT_GET, 4'd7, 31'd60, 32'h0);
		send_request(ACT_GET, 4'd7, 31'd95, 32'h0);
	endtask

	task automatic test_full_list();
		logic [STAMP_W-1:0] stp;
		idle_pct = 57;
		stp = 31'd1000;
		while (int'(list_count[3]) < DEPTH) begin
			stp = stp + STAMP_W'($urandom_range(1, 500));
			send_request(ACT_SET, 4'd3, stp, $urandom());
		end
		send_request(ACT_SET, 4'd3, stp + 31'd10, $urandom());  // dropped
		send_request(ACT_SET, 4'd3, 31'd0, $urandom());
		send_request(ACT_GET, 4'd3, stp, 32'h0);
		send_request(ACT_GET, 4'd3, stp + 31'd1, 32'h0);
		send_request(ACT_GET, 4'd3, list_stamps[3][0], 32'h0);
		send_request(ACT_GET, 4'd3, list_stamps[3][DEPTH/2] + 31'd1, 32'h0);
	endtask

	task automatic run_random_traffic(input int n_items, input int pct);
		int r, k, cnt;
		logic [SLOT_W-1:0]  slot;
		logic [STAMP_W-1:0] stp, last;
		logic [VALUE_W-1:0] val;
		idle_pct = pct;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			val = $urandom();
			if (r < 35) begin
				// sets lean toward low slots so list sizes stay spread out
				slot = SLOT_W'($urandom_range(0, $urandom_range(KEYS - 1)));
				cnt = int'(list_count[slot]);
				k = $urandom_range(99);
				last = (cnt > 0) ? list_stamps[slot][cnt - 1] : STAMP_W'($urandom_range(0, 1000));
				if (k < 5 && cnt > 0)
					stp = last;
				else if (k < 88 && last < STAMP_MAX - 31'd2000)
					stp = last + STAMP_W'($urandom_range(1, 1000));
				else
					stp = STAMP_W'($urandom());
				send_request(ACT_SET, slot, stp, val);
			end else if (r < 40) begin
				send_request(1'($urandom()), SLOT_W'($urandom()), STAMP_W'($urandom()), val);
			end else begin
				slot = SLOT_W'($urandom_range(KEYS - 1));
				cnt = int'(list_count[slot]);
				k = $urandom_range(99);
				if (cnt == 0 || k >= 85) begin
					stp = STAMP_W'($urandom());
				end else begin
					stp = list_stamps[slot][$urandom_range(cnt - 1)];
					if (k >= 40 && k < 65 && stp < STAMP_MAX - 31'd100)
						stp = stp + STAMP_W'($urandom_range(1, 60));
					else if (k >= 65 && k < 75 && list_stamps[slot][0] != '0)
						stp = list_stamps[slot][0] - 31'd1;
					else if (k >= 75 && k < 80)
						stp = '0;
					else if (k >= 80)
						stp = STAMP_MAX;
				end
				send_request(ACT_GET, slot, stp, val);
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		action      = 1'b0;
		key_slot    = '0;
		stamp       = '0;
		value_word  = '0;
		error_count = 0;
		cycle_count = 0;
		idle_pct    = 0;
		for (int s = 0; s < KEYS; s++)
			list_count[s] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_list();
		run_random_traffic(600, 0);
		run_random_traffic(620, 57);
		run_random_traffic(620, 9);

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/tvfs_pkg.sv
rtl/tvfs_probe.sv
rtl/timestamped_value_floor_store.sv
verif/tb_timestamped_value_floor_store.sv
